[hdl/cvs_pkg.sv]
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants for the 2D valid-mode convolution stream unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvs_pkg;

    localparam int DEF_MAX_IMAGE_WIDTH = 1024;
    localparam int DEF_MAX_KERNEL_SIZE = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int KSIZE_W    = 4;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 40;
    localparam int POS_W      = 10;
    localparam int COEF_IDX_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 2'd3;

    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } cvs_state_t;

    typedef struct packed {
        logic load_coef;
        logic load_pixel;
        logic issue;
        logic load_out;
    } cvs_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } cvs_status_t;

endpackage

[hdl/cvs_ctrl.sv]
// ----------------------------------------------------------------------------
// cvs_ctrl
// Sequencer: takes items, steps the tap loop, hands the sum to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvs_ctrl
    import cvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_kind,
    output logic        s_ready,
    input  cvs_status_t status,
    output cvs_cmd_t    cmd
);

    cvs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == KIND_COEF) begin
                        cmd.load_coef = 1'b1;
                    end else begin
                        cmd.load_pixel = 1'b1;
                        if (status.hit) state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.last_tap) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!status.pipe_busy && status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[hdl/cvs_datapath.sv]
// ----------------------------------------------------------------------------
// cvs_datapath
// Registers, kernel and line memories, raster counters, multiply-accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvs_datapath
    import cvs_pkg::*;
#(
    parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_KERNEL_SIZE = DEF_MAX_KERNEL_SIZE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [COEF_IDX_W-1:0]  s_coef_index,
    input  logic signed [SAMPLE_W-1:0] s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_pixel,
    input  logic                   s_start_of_frame,
    input  cvs_cmd_t               cmd,
    output cvs_status_t            status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic signed [SUM_W-1:0] m_conv_sum,
    output logic [POS_W-1:0]       m_out_row,
    output logic [POS_W-1:0]       m_out_col
);

    localparam int CW     = $clog2(MAX_IMAGE_WIDTH);
    localparam int WW     = CW + 1;
    localparam int SW     = (MAX_KERNEL_SIZE > 1) ? $clog2(MAX_KERNEL_SIZE) : 1;
    localparam int KW     = $clog2(MAX_KERNEL_SIZE + 1);
    localparam int KDEPTH = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
    localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int LDEPTH = MAX_KERNEL_SIZE * MAX_IMAGE_WIDTH;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int XW     = ((WW > CFG_DATA_W) ? WW : CFG_DATA_W) + 1;
    localparam int CIW    = (COEF_IDX_W > KAW) ? COEF_IDX_W : KAW;

    logic [CFG_DATA_W-1:0] img_w_reg, res_w_reg;
    logic [KSIZE_W-1:0]    ker_w_reg, ker_h_reg;

    logic [CW-1:0]    col_reg;
    logic [POS_W-1:0] row_reg;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    rows_done_reg;

    logic [CW-1:0]    col0_reg;
    logic [POS_W-1:0] orow_reg;
    logic [KW-1:0]    kw_reg, kh_reg;
    logic [SW-1:0]    r_reg, c_reg, it_slot_reg;

    logic signed [SAMPLE_W-1:0] kmem [KDEPTH];
    logic signed [SAMPLE_W-1:0] lmem [LDEPTH];
    logic signed [SAMPLE_W-1:0] kdata_reg, ldata_reg;
    logic                       rd_vld_reg, prod_vld_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;

    logic                       out_vld_reg;
    logic signed [SUM_W-1:0]    out_sum_reg;
    logic [POS_W-1:0]           out_row_reg, out_col_reg;

    logic [WW-1:0] w_eff;
    logic [KW-1:0] kw_eff, kh_eff;
    logic [CW-1:0] col_cur;
    logic [POS_W-1:0] row_cur;
    logic [SW-1:0] slot_cur, rows_cur, slot_inc;
    logic [XW-1:0] col_p1, kw_x, col0_x;
    logic          hit;
    logic [SW:0]   start_sum;
    logic [SW-1:0] start_slot;
    logic [LAW-1:0] wr_addr, rd_addr;
    logic [KAW-1:0] k_addr;

    // clamp the image width and kernel sizes into their legal ranges
    always_comb begin
        if (img_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(img_w_reg) > MAX_IMAGE_WIDTH) begin
            w_eff = WW'(MAX_IMAGE_WIDTH);
        end else begin
            w_eff = WW'(img_w_reg);
        end
        if (ker_w_reg == '0) begin
            kw_eff = KW'(1);
        end else if (32'(ker_w_reg) > MAX_KERNEL_SIZE) begin
            kw_eff = KW'(MAX_KERNEL_SIZE);
        end else begin
            kw_eff = KW'(ker_w_reg);
        end
        if (ker_h_reg == '0) begin
            kh_eff = KW'(1);
        end else if (32'(ker_h_reg) > MAX_KERNEL_SIZE) begin
            kh_eff = KW'(MAX_KERNEL_SIZE);
        end else begin
            kh_eff = KW'(ker_h_reg);
        end
    end

    always_comb begin
        col_cur  = s_start_of_frame ? '0 : col_reg;
        row_cur  = s_start_of_frame ? '0 : row_reg;
        slot_cur = s_start_of_frame ? '0 : slot_reg;
        rows_cur = s_start_of_frame ? '0 : rows_done_reg;
        col_p1   = XW'(col_cur) + XW'(1);
        kw_x     = XW'(kw_eff);
        col0_x   = col_p1 - kw_x;
        hit      = (32'(rows_cur) + 1 >= 32'(kh_eff)) && (col_p1 >= kw_x)
                   && (col0_x < XW'(res_w_reg));
        start_sum = (SW+1)'(32'(slot_cur) + MAX_KERNEL_SIZE - 32'(kh_eff) + 1);
        if (32'(start_sum) >= MAX_KERNEL_SIZE) begin
            start_slot = SW'(32'(start_sum) - MAX_KERNEL_SIZE);
        end else begin
            start_slot = SW'(start_sum);
        end
        slot_inc = (32'(it_slot_reg) + 1 == MAX_KERNEL_SIZE) ? '0 : it_slot_reg + SW'(1);
        wr_addr  = LAW'(32'(slot_cur) * MAX_IMAGE_WIDTH + 32'(col_cur));
        rd_addr  = LAW'(32'(it_slot_reg) * MAX_IMAGE_WIDTH + 32'(col0_reg) + 32'(c_reg));
        k_addr   = KAW'(32'(r_reg) * MAX_KERNEL_SIZE + 32'(c_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= CFG_DATA_W'(1024);
            res_w_reg <= CFG_DATA_W'(1017);
            ker_w_reg <= KSIZE_W'(8);
            ker_h_reg <= KSIZE_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IMAGE_WIDTH:   img_w_reg <= cfg_wr_data;
                REG_RESULT_WIDTH:  res_w_reg <= cfg_wr_data;
                REG_KERNEL_WIDTH:  ker_w_reg <= cfg_wr_data[KSIZE_W-1:0];
                REG_KERNEL_HEIGHT: ker_h_reg <= cfg_wr_data[KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            rows_done_reg <= '0;
        end else if (cmd.load_pixel) begin
            if (col_p1 >= XW'(w_eff)) begin
                col_reg  <= '0;
                row_reg  <= row_cur + POS_W'(1);
                slot_reg <= (32'(slot_cur) + 1 == MAX_KERNEL_SIZE) ? '0 : slot_cur + SW'(1);
                if (32'(rows_cur) < MAX_KERNEL_SIZE - 1) begin
                    rows_done_reg <= rows_cur + SW'(1);
                end else begin
                    rows_done_reg <= rows_cur;
                end
            end else begin
                col_reg       <= CW'(col_p1);
                row_reg       <= row_cur;
                slot_reg      <= slot_cur;
                rows_done_reg <= rows_cur;
            end
        end
    end

    // tap loop state
    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            col0_reg    <= CW'(col0_x);
            orow_reg    <= row_cur - POS_W'(kh_eff) + POS_W'(1);
            kw_reg      <= kw_eff;
            kh_reg      <= kh_eff;
            r_reg       <= '0;
            c_reg       <= '0;
            it_slot_reg <= start_slot;
        end else if (cmd.issue) begin
            if (32'(c_reg) + 1 == 32'(kw_reg)) begin
                c_reg       <= '0;
                r_reg       <= r_reg + SW'(1);
                it_slot_reg <= slot_inc;
            end else begin
                c_reg <= c_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_coef && (32'(s_coef_index) < KDEPTH)) begin
            kmem[KAW'(CIW'(s_coef_index))] <= s_coef_value;
        end
        kdata_reg <= kmem[k_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            lmem[wr_addr] <= s_pixel;
        end
        ldata_reg <= lmem[rd_addr];
    end

    // multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= kdata_reg * ldata_reg;
        if (cmd.load_pixel) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sum_reg <= acc_reg;
            out_row_reg <= orow_reg;
            out_col_reg <= POS_W'(32'(col0_reg));
        end
    end

    assign status.hit       = hit;
    assign status.last_tap  = (32'(r_reg) + 1 == 32'(kh_reg)) && (32'(c_reg) + 1 == 32'(kw_reg));
    assign status.pipe_busy = rd_vld_reg | prod_vld_reg;
    assign status.out_free  = !out_vld_reg || m_ready;

    assign m_valid    = out_vld_reg;
    assign m_conv_sum = out_sum_reg;
    assign m_out_row  = out_row_reg;
    assign m_out_col  = out_col_reg;

endmodule

[hdl/conv2d_valid_stream_unit.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_stream_unit
// 2D valid-mode cross-correlation over a raster pixel stream.
// ----------------------------------------------------------------------------
// Load the kernel with coefficient items before the first pixel. A coefficient
// item leaves the sequencer idle, as does a pixel item that yields no result;
// one that yields a result holds s_ready low while the single multiply-accumulate
// unit reads one tap per cycle, kernel_height * kernel_width taps in all, from
// the line and kernel memories, then while the read and product registers drain
// and the output is loaded. The load waits while an earlier result is still held
// in the output register by m_ready low. A finished result waits in the output
// register while the next item is taken. The line memory needs no clearing pass.
`timescale 1ns / 1ps

module conv2d_valid_stream_unit
    import cvs_pkg::*;
#(
    parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_KERNEL_SIZE = DEF_MAX_KERNEL_SIZE
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [COEF_IDX_W-1:0]      s_coef_index,
    input  logic signed [SAMPLE_W-1:0] s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_pixel,
    input  logic                       s_start_of_frame,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SUM_W-1:0]    m_conv_sum,
    output logic [POS_W-1:0]           m_out_row,
    output logic [POS_W-1:0]           m_out_col
);

    cvs_cmd_t    cmd;
    cvs_status_t status;

    cvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cvs_datapath #(
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
        .MAX_KERNEL_SIZE (MAX_KERNEL_SIZE)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_coef_index     (s_coef_index),
        .s_coef_value     (s_coef_value),
        .s_pixel          (s_pixel),
        .s_start_of_frame (s_start_of_frame),
        .cmd              (cmd),
        .status           (status),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_conv_sum       (m_conv_sum),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col)
    );

endmodule

[hdl/cvs_checker.sv]
// ----------------------------------------------------------------------------
// cvs_checker
// Port-level checks for the convolution stream unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvs_checker
    import cvs_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_kind,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SUM_W-1:0]    m_conv_sum,
    input logic [POS_W-1:0]           m_out_row,
    input logic [POS_W-1:0]           m_out_col
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_conv_sum)
            && $stable(m_out_row) && $stable(m_out_col))
        else $error("stalled result changed");

    a_coef_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_COEF && !m_valid |=> !m_valid)
        else $error("coefficient transfer produced a result");

    a_pixel_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_PIXEL && !m_valid |=> !m_valid)
        else $error("result appeared too early after pixel transfer");

endmodule

bind conv2d_valid_stream_unit cvs_checker u_cvs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_kind     (s_kind),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_conv_sum (m_conv_sum),
    .m_out_row  (m_out_row),
    .m_out_col  (m_out_col)
);
